>>> rtl/pfa_pkg.sv
// shared constants, types and helper functions of the page frame allocator
package pfa_pkg;

   localparam int NUM_FRAMES  = 1024;
   localparam int FRAME_BYTES = 4096;
   localparam int FB_SHIFT    = $clog2(FRAME_BYTES);
   localparam int WORD_BITS   = 32;
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int NUM_WORDS   = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int COUNT_W     = $clog2(NUM_FRAMES + 1);
   localparam int FREE_W      = 11;
   localparam int CSR_ADDR_W  = 4;
   localparam logic [63:0] VIRT_BASE_RESET = 64'hffff_0000_0000_0000;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_COUNT = 2'd2,
      OP_XLATE = 2'd3
   } pfa_op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NONE_FREE = 2'd1,
      ST_NO_MATCH  = 2'd2
   } pfa_status_type;

   typedef enum logic {
      REG_PHYS_BASE = 1'b0,
      REG_VIRT_BASE = 1'b1
   } pfa_reg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUB,
      S_CHECK,
      S_FREE_RD,
      S_FREE_WR,
      S_SCAN,
      S_DONE
   } pfa_state_type;

   typedef struct packed {
      pfa_op_type  op;
      logic [63:0] address;
   } pfa_req_type;

   typedef struct packed {
      logic [63:0]       result_address;
      logic [FREE_W-1:0] free_frames;
      pfa_status_type    status;
   } pfa_rsp_type;

   typedef struct packed {
      logic load;
      logic sub;
      logic check;
      logic free_rd;
      logic free_wr;
      logic scan;
      logic emit;
   } pfa_cmd_type;

   typedef struct packed {
      pfa_op_type op;
      logic       none_free;
      logic       match;
      logic       found;
      logic       out_free;
   } pfa_sts_type;

   // bits past the end of the pool read as used
   function automatic logic [WORD_BITS-1:0] pad_mask(input logic [WIDX_W-1:0] word);
      logic [WORD_BITS-1:0] pad;
      for (int b = 0; b < WORD_BITS; b++) begin
         pad[b] = (int'(word) * WORD_BITS + b) >= NUM_FRAMES;
      end
      return pad;
   endfunction

endpackage

>>> rtl/page_frame_allocator_core.sv
// First-fit page frame allocator over a pool of NUM_FRAMES frames of FRAME_BYTES each,
// tracked by a used bitmap held in a 32-bit-wide memory that reset marks all free.
// One request is handled at a time; a finished result waits in an output register,
// so the next request beat is taken while the previous result is still stalled.
// Allocation scans the bitmap from word 0 up to the word that holds the lowest free
// frame, reading one bitmap word per cycle through the memory read port; an empty pool
// skips the scan. A free that matches no frame ends without the bitmap write. A result
// that finds the output register still stalled waits in the final state. No clearing
// pass after reset. Registers sit at byte address 0 (physical base of frame 0) and
// 8 (kernel virtual base).
module page_frame_allocator_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pfa_pkg::pfa_req_type            req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pfa_pkg::pfa_rsp_type            rsp_payload,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pfa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [63:0]                     csr_pwdata,
   output logic [63:0]                     csr_prdata,
   output logic                            csr_pready
);
   import pfa_pkg::*;

   logic [63:0] phys_base;
   logic [63:0] virt_base;
   pfa_cmd_type cmd;
   pfa_sts_type sts;

   pfa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .phys_base   (phys_base),
      .virt_base   (virt_base)
   );

   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pfa_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .phys_base   (phys_base),
      .virt_base   (virt_base),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/pfa_csr.sv
// configuration registers: pool physical base and kernel virtual base
module pfa_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pfa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [63:0]                     csr_pwdata,
   output logic [63:0]                     csr_prdata,
   output logic                            csr_pready,
   output logic [63:0]                     phys_base,
   output logic [63:0]                     virt_base
);
   import pfa_pkg::*;

   logic [63:0] phys_base_ff, phys_base_in;
   logic [63:0] virt_base_ff, virt_base_in;
   logic        wr_en;
   pfa_reg_type reg_sel;

   assign wr_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel = pfa_reg_type'(csr_paddr[CSR_ADDR_W-1]);

   always_comb begin
      phys_base_in = phys_base_ff;
      virt_base_in = virt_base_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_PHYS_BASE: phys_base_in = csr_pwdata;
            REG_VIRT_BASE: virt_base_in = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phys_base_ff <= '0;
         virt_base_ff <= VIRT_BASE_RESET;
      end else begin
         phys_base_ff <= phys_base_in;
         virt_base_ff <= virt_base_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_PHYS_BASE: csr_prdata = phys_base_ff;
         REG_VIRT_BASE: csr_prdata = virt_base_ff;
         default:       csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign phys_base  = phys_base_ff;
   assign virt_base  = virt_base_ff;

endmodule

>>> rtl/pfa_ctrl.sv
// controller state machine: sequences one request through the datapath
module pfa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pfa_pkg::pfa_sts_type  sts,
   output pfa_pkg::pfa_cmd_type  cmd
);
   import pfa_pkg::*;

   pfa_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SUB;
         end
         S_SUB: begin
            unique case (sts.op)
               OP_ALLOC: state_in = sts.none_free ? S_DONE : S_SCAN;
               OP_COUNT: state_in = S_DONE;
               OP_FREE,
               OP_XLATE: state_in = S_CHECK;
               default:  state_in = S_DONE;
            endcase
         end
         S_CHECK: begin
            state_in = (sts.op == OP_XLATE) ? S_DONE : S_FREE_RD;
         end
         S_FREE_RD: begin
            state_in = sts.match ? S_FREE_WR : S_DONE;
         end
         S_FREE_WR: begin
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (sts.found) state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         S_SUB:     cmd.sub     = 1'b1;
         S_CHECK:   cmd.check   = 1'b1;
         S_FREE_RD: cmd.free_rd = 1'b1;
         S_FREE_WR: cmd.free_wr = 1'b1;
         S_SCAN:    cmd.scan    = 1'b1;
         S_DONE:    cmd.emit    = sts.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/pfa_dpath.sv
// datapath: request registers, address arithmetic, used bitmap memory and result register
module pfa_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  pfa_pkg::pfa_req_type  req_payload,
   input  logic [63:0]           phys_base,
   input  logic [63:0]           virt_base,
   input  pfa_pkg::pfa_cmd_type  cmd,
   output pfa_pkg::pfa_sts_type  sts,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output pfa_pkg::pfa_rsp_type  rsp_payload
);
   import pfa_pkg::*;

   // used bitmap, one 32-frame word per row
   logic [WORD_BITS-1:0] mem [NUM_WORDS];

   pfa_op_type           op_ff, op_in;
   logic [63:0]          addr_ff, addr_in;
   logic [63:0]          pa_ff, pa_in;
   logic [63:0]          off_ff, off_in;
   logic [63:0]          res_ff, res_in;
   pfa_status_type       st_ff, st_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [WIDX_W-1:0]    ptr_ff, ptr_in;
   logic [WIDX_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [NUM_WORDS-1:0] row_vld_ff, row_vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   pfa_rsp_type          rsp_ff, rsp_in;
   logic [WORD_BITS-1:0] rd_data_ff;

   logic [WIDX_W-1:0]       word_sel;
   logic [BIT_W-1:0]        bit_sel;
   logic [WIDX_W-1:0]       rd_addr;
   logic [WORD_BITS-1:0]    word_raw;
   logic [WORD_BITS-1:0]    word_inv;
   logic [WORD_BITS-1:0]    low_oh;
   logic [BIT_W-1:0]        low_bit;
   logic                    found;
   logic [63:0]             scan_addr;
   logic [WORD_BITS-1:0]    free_mask;
   logic                    free_hit;
   logic                    xl_in_range;
   logic [63:0]             xl_addr;
   logic                    match;
   logic                    none_free;
   logic                    out_free;
   logic                    wr_en;
   logic [WORD_BITS-1:0]    wr_data;

   assign word_sel = off_ff[FB_SHIFT + BIT_W +: WIDX_W];
   assign bit_sel  = off_ff[FB_SHIFT +: BIT_W];
   assign rd_addr  = cmd.scan ? ptr_ff : word_sel;

   // rows never written since reset read as all free
   assign word_raw = rd_vld_ff ? rd_data_ff : '0;
   assign word_inv = ~(word_raw | pad_mask(rd_ptr_ff));
   assign low_oh   = word_inv & (~word_inv + WORD_BITS'(1));
   assign found    = rd_pend_ff && (word_inv != '0);

   always_comb begin
      low_bit = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (low_oh[b]) low_bit = low_bit | BIT_W'(b);
      end
   end

   assign scan_addr = phys_base + (64'({rd_ptr_ff, low_bit}) << FB_SHIFT);

   assign free_mask = WORD_BITS'(1) << bit_sel;
   assign free_hit  = |(word_raw & free_mask);

   assign xl_in_range = (pa_ff >> FB_SHIFT) < 64'(NUM_FRAMES);
   assign xl_addr     = phys_base + (pa_ff & ~64'(FRAME_BYTES - 1));

   assign match = (off_ff[FB_SHIFT-1:0] == '0) && ((off_ff >> FB_SHIFT) < 64'(NUM_FRAMES));

   assign none_free = (count_ff == '0);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign wr_en   = (cmd.scan && found) || cmd.free_wr;
   assign wr_data = cmd.free_wr ? (word_raw & ~free_mask) : (word_raw | low_oh);

   always_comb begin
      op_in        = op_ff;
      addr_in      = addr_ff;
      pa_in        = pa_ff;
      off_in       = off_ff;
      res_in       = res_ff;
      st_in        = st_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_pend_in   = cmd.scan;
      rd_vld_in    = rd_vld_ff;
      row_vld_in   = row_vld_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (cmd.load) begin
         op_in   = req_payload.op;
         addr_in = req_payload.address;
         res_in  = '0;
         st_in   = ST_OK;
      end
      if (cmd.sub) begin
         pa_in  = addr_ff - virt_base;
         ptr_in = '0;
         if (op_ff == OP_ALLOC && none_free) st_in = ST_NONE_FREE;
      end
      if (cmd.check) begin
         off_in = pa_ff - phys_base;
         if (op_ff == OP_XLATE) begin
            if (xl_in_range) res_in = xl_addr;
            else             st_in  = ST_NO_MATCH;
         end
      end
      if (cmd.scan || cmd.free_rd) begin
         rd_ptr_in = rd_addr;
         rd_vld_in = row_vld_ff[rd_addr];
      end
      if (cmd.free_rd && !match) st_in = ST_NO_MATCH;
      if (cmd.scan) begin
         ptr_in = ptr_ff + WIDX_W'(1);
         if (found) begin
            res_in   = scan_addr;
            count_in = count_ff - COUNT_W'(1);
         end
      end
      if (cmd.free_wr && free_hit) count_in = count_ff + COUNT_W'(1);
      if (wr_en) row_vld_in[rd_ptr_ff] = 1'b1;

      if (cmd.emit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.result_address = res_ff;
         rsp_in.free_frames    = FREE_W'(count_ff);
         rsp_in.status         = st_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_W'(NUM_FRAMES);
         rd_pend_ff   <= 1'b0;
         row_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         row_vld_ff   <= row_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      addr_ff   <= addr_in;
      pa_ff     <= pa_in;
      off_ff    <= off_in;
      res_ff    <= res_in;
      st_ff     <= st_in;
      ptr_ff    <= ptr_in;
      rd_ptr_ff <= rd_ptr_in;
      rd_vld_ff <= rd_vld_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[rd_ptr_ff] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign sts.op        = op_ff;
   assign sts.none_free = none_free;
   assign sts.match     = match;
   assign sts.found     = found;
   assign sts.out_free  = out_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/pfa_checker.sv
// port-level checks of the page frame allocator, bound to the top level
module pfa_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input pfa_pkg::pfa_rsp_type  rsp_payload
);
   import pfa_pkg::*;

   // a waiting result beat holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   // one request at a time: the block is busy right after a request beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // failures carry a zero address
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_OK |-> rsp_payload.result_address == '0)
      else $error("failed request returned a non-zero address");

   // nothing left over from before reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind page_frame_allocator_core pfa_checker u_pfa_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

>>> verif/tb.sv
// self-checking testbench for the page frame allocator core
module tb;
   import pfa_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 40;
   localparam logic [63:0] FB    = 64'(FRAME_BYTES);
   localparam logic [63:0] POOL  = 64'(NUM_FRAMES);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   pfa_req_type           req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   pfa_rsp_type           rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [63:0]           csr_pwdata = '0;
   logic [63:0]           csr_prdata;
   logic                  csr_pready;

   // allocator image kept beside the block
   logic [NUM_FRAMES-1:0] frame_in_use = '0;
   int                    free_count = NUM_FRAMES;
   logic [63:0]           phys_base = '0;
   logic [63:0]           virt_base = VIRT_BASE_RESET;

   pfa_rsp_type           pending_rsp_q[$];
   pfa_rsp_type           oldest_rsp;
   int                    error_count = 0;
   int                    quiet_cycles = 0;
   int                    send_idle_pct = 0;
   int                    recv_stall_pct = 0;
   int                    random_beats = 0;
   int                    hold_requests = 0;
   int                    holds_served = 0;
   int                    hold_left = 0;

   page_frame_allocator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [63:0] frame_address(input logic [63:0] idx);
      return phys_base + idx * FB;
   endfunction

   // applies one request to the image and returns the response it should give
   function automatic pfa_rsp_type predict_frame_op(input pfa_op_type op,
                                                    input logic [63:0] address);
      pfa_rsp_type rsp;
      logic [63:0] offset;
      logic [63:0] idx;
      bit          found;
      rsp = '0;
      rsp.status = ST_OK;
      found = 1'b0;
      case (op)
         OP_ALLOC: begin
            for (int i = 0; i < NUM_FRAMES && !found; i++) begin
               if (!frame_in_use[i]) begin
                  frame_in_use[i] = 1'b1;
                  free_count--;
                  rsp.result_address = frame_address(64'(i));
                  found = 1'b1;
               end
            end
            if (!found) rsp.status = ST_NONE_FREE;
         end
         OP_FREE: begin
            offset = address - virt_base - phys_base;
            idx = offset / FB;
            if (offset % FB == 0 && idx < POOL) begin
               if (frame_in_use[idx]) begin
                  frame_in_use[idx] = 1'b0;
                  free_count++;
               end
            end else begin
               rsp.status = ST_NO_MATCH;
            end
         end
         OP_XLATE: begin
            idx = (address - virt_base) / FB;
            if (idx < POOL) rsp.result_address = frame_address(idx);
            else rsp.status = ST_NO_MATCH;
         end
         default: ;
      endcase
      rsp.free_frames = FREE_W'(free_count);
      return rsp;
   endfunction

   // valid stays high between back-to-back beats, lowered only for a gap
   task automatic send_request(input pfa_op_type op, input logic [63:0] address);
      pfa_req_type item;
      item.op = op;
      item.address = address;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      pending_rsp_q.push_back(predict_frame_op(op, address));
   endtask

   task automatic drain_block(input int extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp_q.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_register(input pfa_reg_type sel, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(8 * int'(sel));
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (sel == REG_PHYS_BASE) phys_base = value;
      else virt_base = value;
      @(posedge clock);
   endtask

   task automatic check_register(input pfa_reg_type sel, input logic [63:0] want);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= CSR_ADDR_W'(8 * int'(sel));
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         $display("%0t: register %s expected %h actual %h", $time, sel.name(), want,
                  csr_prdata);
         error_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // mostly well-formed addresses, with a share of noise and near misses
   function automatic pfa_req_type make_random_request(input int alloc_pct);
      pfa_req_type item;
      logic [63:0] idx;
      int          shape;
      item.address = {$urandom, $urandom};
      idx = 64'($urandom_range(NUM_FRAMES - 1));
      shape = $urandom_range(9);
      if ($urandom_range(99) < alloc_pct) begin
         item.op = OP_ALLOC;
      end else begin
         case ($urandom_range(3))
            0: item.op = OP_COUNT;
            1: item.op = OP_XLATE;
            default: item.op = OP_FREE;
         endcase
         if (shape == 8) idx = POOL + 64'($urandom_range(3));
         if (item.op == OP_FREE && shape < 9) begin
            item.address = virt_base + phys_base + idx * FB;
            if (shape == 7) item.address += 64'($urandom_range(FRAME_BYTES - 1, 1));
         end else if (item.op == OP_XLATE && shape < 9) begin
            item.address = virt_base + idx * FB + 64'($urandom_range(FRAME_BYTES - 1));
         end
      end
      return item;
   endfunction

   // idling pattern changes every hundred beats
   task automatic send_random(input int alloc_pct);
      pfa_req_type item;
      case ((random_beats / 100) % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
         default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      random_beats++;
      item = make_random_request(alloc_pct);
      send_request(item.op, item.address);
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_request(OP_COUNT, '0);
      send_request(OP_XLATE, virt_base);
      send_request(OP_XLATE, virt_base + POOL * FB - 1);
      send_request(OP_XLATE, virt_base + POOL * FB);
      send_request(OP_XLATE, virt_base - 1);
      send_request(OP_XLATE, '0);
      send_request(OP_XLATE, '1);
      // frame 0 is not in use yet
      send_request(OP_FREE, virt_base + phys_base);
      send_request(OP_FREE, virt_base + phys_base + 1);
      send_request(OP_FREE, virt_base + phys_base + POOL * FB);
      send_request(OP_FREE, '1);
      send_request(OP_ALLOC, '1);
      send_request(OP_ALLOC, '0);
      send_request(OP_ALLOC, 64'h5555_5555_aaaa_aaaa);
      send_request(OP_FREE, virt_base + phys_base + FB);
      send_request(OP_COUNT, '1);
      send_request(OP_ALLOC, '0);
      send_request(OP_XLATE, virt_base + 2 * FB + FB - 1);
      send_request(OP_FREE, virt_base + phys_base + 2 * FB);
      send_request(OP_FREE, virt_base + phys_base + 2 * FB);
      send_request(OP_COUNT, '0);
      drain_block(4);
   endtask

   task automatic test_registers();
      check_register(REG_PHYS_BASE, phys_base);
      check_register(REG_VIRT_BASE, virt_base);
      write_register(REG_PHYS_BASE, '1);
      write_register(REG_VIRT_BASE, '0);
      check_register(REG_PHYS_BASE, '1);
      check_register(REG_VIRT_BASE, '0);
      // frame addresses wrap past the top of the address space
      send_request(OP_XLATE, POOL * FB - 1);
      send_request(OP_ALLOC, '0);
      send_request(OP_FREE, 64'hffff_ffff_ffff_ffff);
      send_request(OP_FREE, '1 + FB);
      send_request(OP_XLATE, '1);
      drain_block(4);
      write_register(REG_PHYS_BASE, {$urandom, $urandom});
      write_register(REG_VIRT_BASE, VIRT_BASE_RESET);
      check_register(REG_PHYS_BASE, phys_base);
      check_register(REG_VIRT_BASE, virt_base);
   endtask

   task automatic test_pool_exhaustion();
      int guard;
      guard = 0;
      while (free_count > 0 && guard < 4000) begin
         send_random(95);
         guard++;
      end
      repeat (20) send_random(95);
      drain_block(4);
   endtask

   task automatic test_backpressure();
      pfa_req_type item;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_requests++;
      repeat (40) begin
         item = make_random_request(40);
         send_request(item.op, item.address);
      end
      drain_block(4);
   endtask

   task automatic test_churn();
      for (int setting = 0; setting < 4; setting++) begin
         case (setting)
            0: begin
               write_register(REG_PHYS_BASE, '0);
               write_register(REG_VIRT_BASE, VIRT_BASE_RESET);
            end
            1: begin
               write_register(REG_PHYS_BASE, '1);
               write_register(REG_VIRT_BASE, '1);
            end
            2: begin
               write_register(REG_PHYS_BASE, {$urandom, $urandom});
               write_register(REG_VIRT_BASE, '0);
            end
            default: begin
               write_register(REG_PHYS_BASE, {$urandom, $urandom});
               write_register(REG_VIRT_BASE, {$urandom, $urandom});
            end
         endcase
         repeat (25) send_random(35);
         drain_block(4);
      end
   endtask

   // response side: checks each accepted beat and drives the stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp_q.size() == 0) begin
               $display("%0t: unexpected response beat, actual %p", $time, rsp_payload);
               error_count++;
            end else begin
               oldest_rsp = pending_rsp_q.pop_front();
               if (rsp_payload.result_address !== oldest_rsp.result_address) begin
                  $display("%0t: result_address expected %h actual %h", $time,
                           oldest_rsp.result_address, rsp_payload.result_address);
                  error_count++;
               end
               if (rsp_payload.free_frames !== oldest_rsp.free_frames) begin
                  $display("%0t: free_frames expected %0d actual %0d", $time,
                           oldest_rsp.free_frames, rsp_payload.free_frames);
                  error_count++;
               end
               if (rsp_payload.status !== oldest_rsp.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           oldest_rsp.status, rsp_payload.status);
                  error_count++;
               end
            end
         end
         if (hold_left == 0 && hold_requests != holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) hold_left--;
         rsp_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_registers();
      test_pool_exhaustion();
      test_backpressure();
      test_churn();
      drain_block(DRAIN_CYCLES);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
